>>> src/xtea_pkg.sv
// Shared types, constants and round functions for the XTEA block cipher.
`timescale 1ns / 1ps

package xtea_pkg;

  localparam int WORD_W = 32;
  localparam int KEY_WORDS = 4;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] KEY_WORD_0_IDX = 2'd0;
  localparam logic [1:0] KEY_WORD_1_IDX = 2'd1;
  localparam logic [1:0] KEY_WORD_2_IDX = 2'd2;
  localparam logic [1:0] KEY_WORD_3_IDX = 2'd3;

  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] xtea_key_t;

  typedef struct packed {
    logic              op;
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
  } xtea_item_t;

  // DELTA times n, modulo 2^32; only ever called on elaboration constants.
  function automatic logic [WORD_W-1:0] delta_mult(input int unsigned n);
    logic [63:0] prod;
    prod = 64'(DELTA) * 64'(n);
    return prod[WORD_W-1:0];
  endfunction

  // The XTEA mixing term, with the sum and key word already added.
  function automatic logic [WORD_W-1:0] xt_mix(input logic [WORD_W-1:0] v,
                                               input logic [WORD_W-1:0] sum_key);
    logic [WORD_W-1:0] f;
    f = ((v << 4) ^ (v >> 5)) + v;
    return f ^ sum_key;
  endfunction

endpackage

>>> src/xtea_if.sv
// Valid/ready channel interfaces for the XTEA input and result beats.
`timescale 1ns / 1ps

interface xtea_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] first_word;
  logic [31:0] second_word;

  modport source (output valid, output operation, output first_word, output second_word,
                  input ready);
  modport sink (input valid, input operation, input first_word, input second_word,
                output ready);
endinterface

interface xtea_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_first_word;
  logic [31:0] out_second_word;

  modport source (output valid, output out_first_word, output out_second_word,
                  input ready);
  modport sink (input valid, input out_first_word, input out_second_word,
                output ready);
endinterface

>>> src/xtea_stage.sv
// One registered half-round of XTEA, serving both encryption and decryption.
`timescale 1ns / 1ps

module xtea_stage #(
  parameter int ROUND_COUNT = 32,
  parameter int STAGE = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  xtea_pkg::xtea_item_t   in_item,
  input  xtea_pkg::xtea_key_t    key,
  output logic                   valid,
  output xtea_pkg::xtea_item_t   item
);

  localparam int ROUND = STAGE / 2;
  localparam bit FIRST_HALF = (STAGE % 2) == 0;
  localparam int unsigned ENC_STEPS = ROUND + (FIRST_HALF ? 0 : 1);
  localparam int unsigned DEC_STEPS = ROUND_COUNT - ROUND - (FIRST_HALF ? 0 : 1);
  localparam logic [31:0] ENC_SUM = xtea_pkg::delta_mult(ENC_STEPS);
  localparam logic [31:0] DEC_SUM = xtea_pkg::delta_mult(DEC_STEPS);
  // The first half of an encryption round keys from the low sum bits, the
  // second from bits 12:11; decryption walks the same schedule backwards.
  localparam logic [1:0] ENC_IDX = FIRST_HALF ? ENC_SUM[1:0] : ENC_SUM[12:11];
  localparam logic [1:0] DEC_IDX = FIRST_HALF ? DEC_SUM[12:11] : DEC_SUM[1:0];

  logic                 upd_v0;
  logic [31:0]          src_word;
  logic [31:0]          dst_word;
  logic [31:0]          sum_key;
  logic [31:0]          mixed;
  logic [31:0]          result;
  xtea_pkg::xtea_item_t item_next;

  always_comb begin
    upd_v0 = (in_item.op == xtea_pkg::OP_ENCRYPT) == FIRST_HALF;
    src_word = upd_v0 ? in_item.v1 : in_item.v0;
    dst_word = upd_v0 ? in_item.v0 : in_item.v1;
    if (in_item.op == xtea_pkg::OP_DECRYPT) begin
      sum_key = DEC_SUM + key[DEC_IDX];
    end else begin
      sum_key = ENC_SUM + key[ENC_IDX];
    end
    mixed = xtea_pkg::xt_mix(src_word, sum_key);
    result = (in_item.op == xtea_pkg::OP_DECRYPT) ? dst_word - mixed : dst_word + mixed;
    item_next = in_item;
    if (upd_v0) begin
      item_next.v0 = result;
    end else begin
      item_next.v1 = result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item <= item_next;
    end
  end

endmodule

>>> src/xtea_block_cipher.sv
// Top level of the pipelined XTEA cipher with its key register port.
`timescale 1ns / 1ps

// Usage:
//   blk_in carries one beat per 64-bit block: operation (0 encrypt, 1 decrypt)
//   and the block as first_word and second_word, big-endian. blk_out returns
//   one beat per block with out_first_word and out_second_word, in order.
//   The 128-bit key is written through the APB port: key_word_0..3 at byte
//   addresses 0, 4, 8 and 12. Change it only while no block is in flight.
// Pipeline:
//   Every half-round is one pipeline stage, 2*ROUND_COUNT stages in all, and
//   the last stage feeds the output register. A new block is taken every
//   cycle while blk_in.ready is high (see Stalls).
// Stalls:
//   A stalled receiver holds the output register; one more result goes into a
//   skid register, after which blk_in.ready drops and the whole pipeline holds
//   until the output beat is taken. Nothing is lost or repeated.
// Reset:
//   rst clears every valid bit and the key registers to zero.
module xtea_block_cipher #(
  parameter int ROUND_COUNT = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  xtea_in_if.sink                           blk_in,
  xtea_out_if.source                        blk_out,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [xtea_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [xtea_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [xtea_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int STAGES = 2 * ROUND_COUNT;

  xtea_pkg::xtea_key_t  key;
  logic                 cfg_write;
  logic [1:0]           cfg_idx;

  logic                 en;
  logic                 stage_in_valid [STAGES];
  xtea_pkg::xtea_item_t stage_in_item [STAGES];
  logic                 stage_valid [STAGES];
  xtea_pkg::xtea_item_t stage_item [STAGES];

  logic                 out_valid;
  xtea_pkg::xtea_item_t out_item;
  logic                 skid_valid;
  xtea_pkg::xtea_item_t skid_item;

  // Key registers.
  assign pready = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata = key[cfg_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_write) begin
      case (cfg_idx)
        xtea_pkg::KEY_WORD_0_IDX: key[0] <= pwdata;
        xtea_pkg::KEY_WORD_1_IDX: key[1] <= pwdata;
        xtea_pkg::KEY_WORD_2_IDX: key[2] <= pwdata;
        xtea_pkg::KEY_WORD_3_IDX: key[3] <= pwdata;
        default: key <= key;
      endcase
    end
  end

  // The pipeline moves as one while the skid register is free.
  assign en = !skid_valid;
  assign blk_in.ready = en;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    if (s == 0) begin : g_head
      assign stage_in_valid[s] = blk_in.valid;
      assign stage_in_item[s] = '{op: blk_in.operation, v0: blk_in.first_word,
                                  v1: blk_in.second_word};
    end else begin : g_body
      assign stage_in_valid[s] = stage_valid[s-1];
      assign stage_in_item[s] = stage_item[s-1];
    end

    xtea_stage #(
      .ROUND_COUNT (ROUND_COUNT),
      .STAGE       (s)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (stage_in_valid[s]),
      .in_item  (stage_in_item[s]),
      .key      (key),
      .valid    (stage_valid[s]),
      .item     (stage_item[s])
    );
  end

  // Output register with a one-beat skid behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || blk_out.ready) begin
      if (skid_valid) begin
        out_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= stage_valid[STAGES-1];
      end
    end else if (stage_valid[STAGES-1] && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || blk_out.ready) begin
      out_item <= skid_valid ? skid_item : stage_item[STAGES-1];
    end else if (!skid_valid) begin
      skid_item <= stage_item[STAGES-1];
    end
  end

  assign blk_out.valid = out_valid;
  assign blk_out.out_first_word = out_item.v0;
  assign blk_out.out_second_word = out_item.v1;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a beat while the output register is empty");

  a_skid_catches: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !blk_out.ready && stage_valid[STAGES-1] && !skid_valid) |=> skid_valid)
    else $error("result leaving the pipeline was not caught by the skid register");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && blk_out.ready) |=> (!skid_valid && out_valid))
    else $error("skid beat was not moved into the output register");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!out_valid && !skid_valid))
    else $error("output side holds a beat after reset");
`endif

endmodule
